// ----- hdl/flot_pkg.sv -----
// ----------------------------------------------------------------------------
// flot_pkg
// Shared types, codes and the control store for the order tracker.
// ----------------------------------------------------------------------------
package flot_pkg;

    localparam int ID_W        = 6;
    localparam int CNT_W       = 7;
    localparam int OP_W        = 3;
    localparam int ST_W        = 2;
    localparam int ENTRIES_DEF = 64;
    localparam int STEP_W      = 3;
    localparam int COND_W      = 3;

    localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE   = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_OLD  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_NEW  = 3'd3;
    localparam logic [OP_W-1:0] OP_TOUCH    = 3'd4;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [ST_W-1:0] ST_DUP    = 2'd2;
    localparam logic [ST_W-1:0] ST_ABSENT = 2'd3;

    localparam logic [STEP_W-1:0] S_IDLE   = 3'd0;
    localparam logic [STEP_W-1:0] S_CHK    = 3'd1;
    localparam logic [STEP_W-1:0] S_SPLIT  = 3'd2;
    localparam logic [STEP_W-1:0] S_READ   = 3'd3;
    localparam logic [STEP_W-1:0] S_UNLINK = 3'd4;
    localparam logic [STEP_W-1:0] S_LINK_A = 3'd5;
    localparam logic [STEP_W-1:0] S_LINK_B = 3'd6;
    localparam logic [STEP_W-1:0] S_DONE   = 3'd7;

    localparam logic [COND_W-1:0] C_ALWAYS  = 3'd0;
    localparam logic [COND_W-1:0] C_ACCEPT  = 3'd1;
    localparam logic [COND_W-1:0] C_NOWORK  = 3'd2;
    localparam logic [COND_W-1:0] C_INSERT  = 3'd3;
    localparam logic [COND_W-1:0] C_TOUCH   = 3'd4;
    localparam logic [COND_W-1:0] C_OUTFREE = 3'd5;

    typedef struct packed {
        logic eval;
        logic read;
        logic unlink;
        logic link_a;
        logic link_b;
        logic out;
    } t_act;

    typedef struct packed {
        t_act               act;
        logic [COND_W-1:0]  cond;
        logic [STEP_W-1:0]  tgt_t;
        logic [STEP_W-1:0]  tgt_f;
    } t_uword;

    localparam t_act A_NONE   = '{eval: 1'b0, read: 1'b0, unlink: 1'b0,
                                  link_a: 1'b0, link_b: 1'b0, out: 1'b0};
    localparam t_act A_EVAL   = '{eval: 1'b1, read: 1'b0, unlink: 1'b0,
                                  link_a: 1'b0, link_b: 1'b0, out: 1'b0};
    localparam t_act A_READ   = '{eval: 1'b0, read: 1'b1, unlink: 1'b0,
                                  link_a: 1'b0, link_b: 1'b0, out: 1'b0};
    localparam t_act A_UNLINK = '{eval: 1'b0, read: 1'b0, unlink: 1'b1,
                                  link_a: 1'b0, link_b: 1'b0, out: 1'b0};
    localparam t_act A_LINK_A = '{eval: 1'b0, read: 1'b0, unlink: 1'b0,
                                  link_a: 1'b1, link_b: 1'b0, out: 1'b0};
    localparam t_act A_LINK_B = '{eval: 1'b0, read: 1'b0, unlink: 1'b0,
                                  link_a: 1'b0, link_b: 1'b1, out: 1'b0};
    localparam t_act A_OUT    = '{eval: 1'b0, read: 1'b0, unlink: 1'b0,
                                  link_a: 1'b0, link_b: 1'b0, out: 1'b1};

    function automatic t_uword f_urom(input logic [STEP_W-1:0] step);
        t_uword w;
        case (step)
            S_IDLE:   w = '{act: A_NONE,   cond: C_ACCEPT,  tgt_t: S_CHK,    tgt_f: S_IDLE};
            S_CHK:    w = '{act: A_EVAL,   cond: C_NOWORK,  tgt_t: S_DONE,   tgt_f: S_SPLIT};
            S_SPLIT:  w = '{act: A_NONE,   cond: C_INSERT,  tgt_t: S_LINK_A, tgt_f: S_READ};
            S_READ:   w = '{act: A_READ,   cond: C_ALWAYS,  tgt_t: S_UNLINK, tgt_f: S_UNLINK};
            S_UNLINK: w = '{act: A_UNLINK, cond: C_TOUCH,   tgt_t: S_LINK_A, tgt_f: S_DONE};
            S_LINK_A: w = '{act: A_LINK_A, cond: C_ALWAYS,  tgt_t: S_LINK_B, tgt_f: S_LINK_B};
            S_LINK_B: w = '{act: A_LINK_B, cond: C_ALWAYS,  tgt_t: S_DONE,   tgt_f: S_DONE};
            S_DONE:   w = '{act: A_OUT,    cond: C_OUTFREE, tgt_t: S_IDLE,   tgt_f: S_DONE};
            default:  w = '{act: A_NONE,   cond: C_ALWAYS,  tgt_t: S_IDLE,   tgt_f: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- hdl/fifo_lru_order_tracker.sv -----
// ----------------------------------------------------------------------------
// fifo_lru_order_tracker
// Doubly linked recency/arrival list over entry ids, run by a microcoded
// sequencer.
// ----------------------------------------------------------------------------
// One transaction is worked at a time; o_in_stall is low only while the
// sequencer sits idle. After the check step an insert runs split and both
// link steps, a remove or pop runs split, read and unlink, and an LRU touch
// runs split, read, unlink and both link steps; a failed operation, a pop of
// an empty list, a touch in FIFO mode or an unused code goes straight to the
// final step. The control store sets this order around the two link memories,
// each with one write and one registered read per cycle. The result sits in
// an output register, so a new transaction is taken while an earlier result
// still waits; the sequencer holds in its final step only when that
// register is occupied and stalled. Link memories need no clearing after reset.
// ----------------------------------------------------------------------------
module fifo_lru_order_tracker
    import flot_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [OP_W-1:0]  i_opcode,
    input  logic [ID_W-1:0]  i_entry_id,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [ID_W-1:0]  o_popped_id,
    output logic [ST_W-1:0]  o_status,
    output logic [CNT_W-1:0] o_count
);

    localparam int ENTRIES = ENTRIES_DEF;
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [STEP_W-1:0] r_step, n_step;
    logic              r_mode;
    logic [OP_W-1:0]   r_op;
    logic [ID_W-1:0]   r_id, n_id;
    logic [ID_W-1:0]   r_newest, n_newest;
    logic [ID_W-1:0]   r_oldest, n_oldest;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ST_W-1:0]   r_status, n_status;
    logic [ID_W-1:0]   r_popped, n_popped;
    logic [ENTRIES-1:0] r_tracked;

    logic              r_ovalid;
    logic [ID_W-1:0]   r_o_popped;
    logic [ST_W-1:0]   r_o_status;
    logic [CNT_W-1:0]  r_o_count;

    logic [ID_W-1:0]   r_older_mem [ENTRIES];
    logic [ID_W-1:0]   r_newer_mem [ENTRIES];
    logic [ID_W-1:0]   r_older_rd;
    logic [ID_W-1:0]   r_newer_rd;

    logic              older_we, newer_we;
    logic [ID_W-1:0]   older_wa, newer_wa;
    logic [ID_W-1:0]   older_wd, newer_wd;

    t_uword            uw;
    logic              in_acc;
    logic              out_free;
    logic              id_ok;
    logic              trk;
    logic              c_work;
    logic              cond_hit;
    logic              cnt_zero;
    logic              cnt_le1;
    logic              trk_clr;
    logic              trk_set;

    assign uw       = f_urom(r_step);
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_ovalid || !i_out_stall;
    assign id_ok    = (32'(r_id) < ENTRIES);
    assign trk      = id_ok && r_tracked[r_id[AW-1:0]];
    assign cnt_zero = (r_count == '0);
    assign cnt_le1  = (r_count <= CNT_W'(1));

    assign o_in_stall  = (r_step != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_popped_id = r_o_popped;
    assign o_status    = r_o_status;
    assign o_count     = r_o_count;

    always_comb begin
        n_status = ST_OK;
        n_popped = '0;
        n_id     = r_id;
        c_work   = 1'b0;
        case (r_op)
            OP_INSERT: begin
                if (!id_ok) begin
                    n_status = ST_ABSENT;
                end else if (trk) begin
                    n_status = ST_DUP;
                end else begin
                    c_work = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (!trk) begin
                    n_status = ST_ABSENT;
                end else begin
                    c_work = 1'b1;
                end
            end
            OP_POP_OLD, OP_POP_NEW: begin
                if (cnt_zero) begin
                    n_status = ST_EMPTY;
                end else begin
                    c_work   = 1'b1;
                    n_popped = (r_op == OP_POP_OLD) ? r_oldest : r_newest;
                    n_id     = n_popped;
                end
            end
            OP_TOUCH: begin
                if (!trk) begin
                    n_status = ST_ABSENT;
                end else begin
                    c_work = r_mode;
                end
            end
            default: begin
                c_work = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (uw.cond)
            C_ALWAYS:  cond_hit = 1'b1;
            C_ACCEPT:  cond_hit = in_acc;
            C_NOWORK:  cond_hit = !c_work;
            C_INSERT:  cond_hit = (r_op == OP_INSERT);
            C_TOUCH:   cond_hit = (r_op == OP_TOUCH);
            C_OUTFREE: cond_hit = out_free;
            default:   cond_hit = 1'b1;
        endcase
        n_step = cond_hit ? uw.tgt_t : uw.tgt_f;
    end

    always_comb begin
        n_newest = r_newest;
        n_oldest = r_oldest;
        n_count  = r_count;
        older_we = 1'b0;
        newer_we = 1'b0;
        older_wa = r_id;
        newer_wa = r_id;
        older_wd = r_newest;
        newer_wd = r_id;
        trk_clr  = 1'b0;
        trk_set  = 1'b0;
        if (uw.act.unlink) begin
            trk_clr = 1'b1;
            if (cnt_le1) begin
                n_count = '0;
            end else begin
                n_count = r_count - CNT_W'(1);
                if (r_id == r_newest) begin
                    n_newest = r_older_rd;
                end else if (r_id == r_oldest) begin
                    n_oldest = r_newer_rd;
                end else begin
                    older_we = 1'b1;
                    older_wa = r_newer_rd;
                    older_wd = r_older_rd;
                    newer_we = 1'b1;
                    newer_wa = r_older_rd;
                    newer_wd = r_newer_rd;
                end
            end
        end
        if (uw.act.link_a) begin
            older_we = 1'b1;
            older_wa = r_id;
            older_wd = r_newest;
            newer_we = !cnt_zero;
            newer_wa = r_newest;
            newer_wd = r_id;
        end
        if (uw.act.link_b) begin
            newer_we = 1'b1;
            newer_wa = r_id;
            newer_wd = r_id;
            trk_set  = 1'b1;
            n_newest = r_id;
            n_count  = r_count + CNT_W'(1);
            if (cnt_zero) begin
                n_oldest = r_id;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= S_IDLE;
            r_mode    <= 1'b0;
            r_tracked <= '0;
            r_newest  <= '0;
            r_oldest  <= '0;
            r_count   <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_step   <= n_step;
            r_newest <= n_newest;
            r_oldest <= n_oldest;
            r_count  <= n_count;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (trk_clr) begin
                r_tracked[r_id[AW-1:0]] <= 1'b0;
            end
            if (trk_set) begin
                r_tracked[r_id[AW-1:0]] <= 1'b1;
            end
            if (uw.act.out && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op <= i_opcode;
            r_id <= i_entry_id;
        end else if (uw.act.eval) begin
            r_id <= n_id;
        end
        if (uw.act.eval) begin
            r_status <= n_status;
            r_popped <= n_popped;
        end
        if (uw.act.out && out_free) begin
            r_o_popped <= r_popped;
            r_o_status <= r_status;
            r_o_count  <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (older_we) begin
            r_older_mem[older_wa[AW-1:0]] <= older_wd;
        end
        if (newer_we) begin
            r_newer_mem[newer_wa[AW-1:0]] <= newer_wd;
        end
        if (uw.act.read) begin
            r_older_rd <= r_older_mem[r_id[AW-1:0]];
            r_newer_rd <= r_newer_mem[r_id[AW-1:0]];
        end
    end

endmodule

// ----- hdl/flot_chk.sv -----
// ----------------------------------------------------------------------------
// flot_chk
// Port-level checks for the order tracker, bound to the top level.
// ----------------------------------------------------------------------------
module flot_chk
    import flot_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_cfg_we,
    input logic             i_cfg_wdata,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic [OP_W-1:0]  i_opcode,
    input logic [ID_W-1:0]  i_entry_id,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [ID_W-1:0]  o_popped_id,
    input logic [ST_W-1:0]  o_status,
    input logic [CNT_W-1:0] o_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_popped_id)
            && $stable(o_status) && $stable(o_count))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transaction taken while busy");

    a_fail_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> (o_popped_id == '0))
        else $error("failed operation reports a popped id");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_EMPTY) |-> (o_count == '0))
        else $error("empty status with nonzero count");

    a_dup_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_DUP) |-> (o_count != '0))
        else $error("duplicate status with empty list");

endmodule

bind fifo_lru_order_tracker flot_chk u_flot_chk (.*);
